### design/kpt_pkg.sv
// ----------------------------------------------------------------------------
// Key-to-pointer translator package
// Field widths, event and axis codes, key numbers and speed constants.
// ----------------------------------------------------------------------------
package kpt_pkg;

  localparam int TYPE_W  = 5;
  localparam int CODE_W  = 10;
  localparam int KVAL_W  = 2;
  localparam int VALUE_W = 11;
  localparam int SPEED_CFG_W = 10;

  localparam int SPEED_MAX_DEF = 1023;
  localparam int SPEED_STEP    = 10;
  localparam int SPEED_RESET   = 10;

  typedef logic [TYPE_W-1:0]         type_t;
  typedef logic [CODE_W-1:0]         code_t;
  typedef logic [KVAL_W-1:0]         kval_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SPEED_CFG_W-1:0]    speed_cfg_t;

  localparam type_t EVT_SYNC = 5'd0;
  localparam type_t EVT_KEY  = 5'd1;
  localparam type_t EVT_REL  = 5'd2;

  localparam code_t AX_X      = 10'd0;
  localparam code_t AX_Y      = 10'd1;
  localparam code_t AX_WHEEL  = 10'd8;
  localparam code_t BUTTON_L  = 10'd272;
  localparam code_t BUTTON_R  = 10'd273;
  localparam code_t CODE_NONE = 10'd0;

  localparam code_t K_MOD   = 10'd92;
  localparam code_t K_F     = 10'd33;
  localparam code_t K_B     = 10'd48;
  localparam code_t K_N     = 10'd49;
  localparam code_t K_P     = 10'd25;
  localparam code_t K_I     = 10'd23;
  localparam code_t K_K     = 10'd37;
  localparam code_t K_SPACE = 10'd57;
  localparam code_t K_L     = 10'd38;
  localparam code_t K_U     = 10'd22;
  localparam code_t K_D     = 10'd32;

  localparam kval_t KV_RELEASE = 2'd0;
  localparam kval_t KV_PRESS   = 2'd1;
  localparam kval_t KV_REPEAT  = 2'd2;

  localparam value_t VAL_ZERO      = 11'sd0;
  localparam value_t VAL_ONE       = 11'sd1;
  localparam value_t VAL_MINUS_ONE = -11'sd1;

endpackage

### design/kpt_in_if.sv
// ----------------------------------------------------------------------------
// Key event channel
// Valid/ready channel carrying one keyboard event word.
// ----------------------------------------------------------------------------
interface kpt_in_if;
  logic          valid;
  logic          ready;
  kpt_pkg::type_t event_type;
  kpt_pkg::code_t key_code;
  kpt_pkg::kval_t key_value;

  modport source (output valid, output event_type, output key_code, output key_value,
                  input ready);
  modport sink   (input valid, input event_type, input key_code, input key_value,
                  output ready);
endinterface

### design/kpt_out_if.sv
// ----------------------------------------------------------------------------
// Pointer event channel
// Valid/ready channel carrying one pointer event word.
// ----------------------------------------------------------------------------
interface kpt_out_if;
  logic            valid;
  logic            ready;
  kpt_pkg::type_t  out_type;
  kpt_pkg::code_t  out_code;
  kpt_pkg::value_t out_value;
  logic            last;

  modport source (output valid, output out_type, output out_code, output out_value,
                  output last, input ready);
  modport sink   (input valid, input out_type, input out_code, input out_value,
                  input last, output ready);
endinterface

### design/kpt_cfg_if.sv
// ----------------------------------------------------------------------------
// Speed configuration channel
// Valid/ready write channel carrying the initial pointer speed.
// ----------------------------------------------------------------------------
interface kpt_cfg_if;
  logic                valid;
  logic                ready;
  kpt_pkg::speed_cfg_t initial_speed;

  modport source (output valid, output initial_speed, input ready);
  modport sink   (input valid, input initial_speed, output ready);
endinterface

### design/key_to_pointer_translator.sv
// ----------------------------------------------------------------------------
// Key-to-pointer translator
// Turns keyboard words into pointer motion, wheel and button words while the
// modifier key is held; each pointer word is followed by a sync word.
// ----------------------------------------------------------------------------
// A key word is taken into an input register, decoded combinationally against
// the modifier flag and pointer speed, and the resulting pair (pointer word,
// then sync word with last set) is held in a result register. The input
// register holds one further key word while a pair drains, and a new pair is
// loaded as the sync word of the last one is taken, so pairs follow without a gap.
// Key words that produce nothing pass at one per cycle while no pair drains.
// An accepted word goes through the input register, then the result register,
// before its first result word appears. Speed writes are always ready.
module key_to_pointer_translator #(
  parameter int SPEED_MAX = kpt_pkg::SPEED_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  kpt_in_if.sink    in_ch,
  kpt_out_if.source out_ch,
  kpt_cfg_if.sink   cfg_ch
);
  import kpt_pkg::*;

  localparam int SW = $clog2(SPEED_MAX + 1);
  localparam int CW = ((SW > VALUE_W) ? SW : VALUE_W) + 1;

  localparam logic [CW-1:0] MAX_W   = CW'(SPEED_MAX);
  localparam logic [CW-1:0] STEP_W  = CW'(SPEED_STEP);
  localparam logic [CW-1:0] RESET_W = CW'(SPEED_RESET);

  logic           in_v_r;
  type_t          in_type_r;
  code_t          in_code_r;
  kval_t          in_kval_r;

  logic           pair_v_r;
  logic           phase_r;
  type_t          ev_type_r,  ev_type_nxt;
  code_t          ev_code_r,  ev_code_nxt;
  value_t         ev_value_r, ev_value_nxt;

  logic           held_r,  held_nxt;
  logic [SW-1:0]  speed_r, speed_nxt;

  logic           out_fire, pair_free, proc, in_fire, cfg_fire, emit, moving;
  logic [CW-1:0]  speed_w, cfg_w, up_w, neg_w;

  assign out_fire  = out_ch.valid & out_ch.ready;
  assign pair_free = ~pair_v_r | (out_ch.ready & phase_r);
  assign proc      = in_v_r & pair_free;
  assign in_ch.ready = ~in_v_r | pair_free;
  assign in_fire   = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire  = cfg_ch.valid;

  assign speed_w = CW'(speed_r);
  assign cfg_w   = CW'(cfg_ch.initial_speed);
  assign up_w    = speed_w + STEP_W;
  assign neg_w   = '0 - speed_w;
  assign moving  = (in_kval_r == KV_PRESS) | (in_kval_r == KV_REPEAT);

  always_comb begin
    emit         = 1'b0;
    ev_type_nxt  = EVT_SYNC;
    ev_code_nxt  = CODE_NONE;
    ev_value_nxt = VAL_ZERO;
    held_nxt     = held_r;
    speed_nxt    = speed_r;
    if (cfg_fire) begin
      speed_nxt = (cfg_w > MAX_W) ? MAX_W[SW-1:0] : cfg_w[SW-1:0];
    end else if (proc && (in_type_r == EVT_KEY)) begin
      if (in_code_r == K_MOD) begin
        held_nxt = (in_kval_r != KV_RELEASE);
      end else if (held_r) begin
        case (in_code_r)
          K_F: begin
            emit = moving; ev_type_nxt = EVT_REL; ev_code_nxt = AX_X;
            ev_value_nxt = speed_w[VALUE_W-1:0];
          end
          K_B: begin
            emit = moving; ev_type_nxt = EVT_REL; ev_code_nxt = AX_X;
            ev_value_nxt = neg_w[VALUE_W-1:0];
          end
          K_N: begin
            emit = moving; ev_type_nxt = EVT_REL; ev_code_nxt = AX_Y;
            ev_value_nxt = speed_w[VALUE_W-1:0];
          end
          K_P: begin
            emit = moving; ev_type_nxt = EVT_REL; ev_code_nxt = AX_Y;
            ev_value_nxt = neg_w[VALUE_W-1:0];
          end
          K_I: begin
            emit = moving; ev_type_nxt = EVT_REL; ev_code_nxt = AX_WHEEL;
            ev_value_nxt = VAL_ONE;
          end
          K_K: begin
            emit = moving; ev_type_nxt = EVT_REL; ev_code_nxt = AX_WHEEL;
            ev_value_nxt = VAL_MINUS_ONE;
          end
          K_SPACE: begin
            emit = (in_kval_r == KV_PRESS) | (in_kval_r == KV_RELEASE);
            ev_type_nxt = EVT_KEY; ev_code_nxt = BUTTON_L;
            ev_value_nxt = (in_kval_r == KV_PRESS) ? VAL_ONE : VAL_ZERO;
          end
          K_L: begin
            emit = (in_kval_r == KV_PRESS) | (in_kval_r == KV_RELEASE);
            ev_type_nxt = EVT_KEY; ev_code_nxt = BUTTON_R;
            ev_value_nxt = (in_kval_r == KV_PRESS) ? VAL_ONE : VAL_ZERO;
          end
          K_U: begin
            if (in_kval_r == KV_RELEASE) begin
              speed_nxt = (up_w > MAX_W) ? MAX_W[SW-1:0] : up_w[SW-1:0];
            end
          end
          K_D: begin
            if ((in_kval_r == KV_RELEASE) && (speed_w > STEP_W)) begin
              speed_nxt = speed_r - STEP_W[SW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      pair_v_r <= 1'b0;
      phase_r  <= 1'b0;
      held_r   <= 1'b0;
      speed_r  <= RESET_W[SW-1:0];
    end else begin
      held_r  <= held_nxt;
      speed_r <= speed_nxt;
      if (in_fire) begin
        in_v_r <= 1'b1;
      end else if (proc) begin
        in_v_r <= 1'b0;
      end
      if (proc) begin
        pair_v_r <= emit;
        phase_r  <= 1'b0;
      end else if (out_fire) begin
        pair_v_r <= ~phase_r;
        phase_r  <= ~phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_type_r <= in_ch.event_type;
      in_code_r <= in_ch.key_code;
      in_kval_r <= in_ch.key_value;
    end
    if (proc && emit) begin
      ev_type_r  <= ev_type_nxt;
      ev_code_r  <= ev_code_nxt;
      ev_value_r <= ev_value_nxt;
    end
  end

  assign out_ch.valid     = pair_v_r;
  assign out_ch.last      = phase_r;
  assign out_ch.out_type  = phase_r ? EVT_SYNC  : ev_type_r;
  assign out_ch.out_code  = phase_r ? CODE_NONE : ev_code_r;
  assign out_ch.out_value = phase_r ? VAL_ZERO  : ev_value_r;

endmodule

### design/kpt_checker.sv
// ----------------------------------------------------------------------------
// Key-to-pointer translator checker
// Port-level properties of the pointer word pairs, bound to the top level.
// ----------------------------------------------------------------------------
module kpt_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input kpt_pkg::type_t  out_type,
  input kpt_pkg::code_t  out_code,
  input kpt_pkg::value_t out_value,
  input logic            out_last
);
  import kpt_pkg::*;

  a_sync_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_last))
    else $error("pointer word not followed by sync word");

  a_sync_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |->
      (out_type == EVT_SYNC && out_code == CODE_NONE && out_value == VAL_ZERO))
    else $error("sync word carries non-zero fields");

  a_first_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_type == EVT_KEY || out_type == EVT_REL))
    else $error("first word of pair has wrong type");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_type) && $stable(out_code) && $stable(out_value)
       && $stable(out_last)))
    else $error("stalled word changed");

endmodule

bind key_to_pointer_translator kpt_checker u_kpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_type  (out_ch.out_type),
  .out_code  (out_ch.out_code),
  .out_value (out_ch.out_value),
  .out_last  (out_ch.last)
);
